@@ rtl/core/stm_pkg.sv @@
// ----------------------------------------------------------------------------
// stm_pkg: shared types, constants and helpers of the stereo track mixer
// Widths of samples, gains, products and the pipelined divider, the stage
// records that pass between modules, and one restoring division step.
// ----------------------------------------------------------------------------
package stm_pkg;

  // Sample and gain widths.
  localparam int SAMPLE_BITS = 16;
  localparam int GAIN_BITS   = 8;
  localparam int TRACKS      = 4;

  // Packed gain register and configuration data widths.
  localparam int GREG_W = TRACKS * GAIN_BITS;
  localparam int CFG_W  = (GREG_W > 8) ? GREG_W : 8;
  localparam int CFG_IDX_W = 3;

  // Product of a signed sample and an unsigned gain, and the sum of four.
  localparam int PROD_W = SAMPLE_BITS + GAIN_BITS + 1;
  localparam int ACC_W  = PROD_W + 2;
  localparam int MAG_W  = ACC_W;

  // Total of all eight gains.
  localparam int TOT_W = GAIN_BITS + 3;

  // Divider: one quotient bit per step, a few steps per register stage.
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = (SAMPLE_BITS + DIV_STEPS - 1) / DIV_STEPS;

  // Products, sum, divider stages and the output register.
  localparam int LATENCY = DIV_STAGES + 3;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GAINS_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAINS_RIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRACK_ENABLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRACK_MODE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TRACK_MAP    = 3'd4;

  // Track modes; the unused code behaves as four-track mode.
  localparam logic [1:0] MODE_ONE  = 2'd0;
  localparam logic [1:0] MODE_TWO  = 2'd1;
  localparam logic [1:0] MODE_FOUR = 2'd2;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [GREG_W-1:0] gains_left;
    logic [GREG_W-1:0] gains_right;
    logic [TRACKS-1:0] track_enable;
    logic [1:0]        track_mode;
    logic [7:0]        track_map;
  } cfg_t;

  // Registered products of one item.
  typedef struct packed {
    logic                          valid;
    logic [TRACKS-1:0][PROD_W-1:0] left;
    logic [TRACKS-1:0][PROD_W-1:0] right;
  } prod_t;

  // Sign and magnitude of one channel entering the divider.
  typedef struct packed {
    logic             valid;
    logic             neg;
    logic [MAG_W-1:0] mag;
  } div_in_t;

  // Unsigned quotient and sign leaving the divider.
  typedef struct packed {
    logic                   valid;
    logic                   neg;
    logic [SAMPLE_BITS-1:0] quo;
  } div_out_t;

  // Result of one restoring division step.
  typedef struct packed {
    logic [TOT_W-1:0] rem;
    logic             q;
  } step_t;

  // Shift one dividend bit into the remainder and subtract the divisor if it fits.
  function automatic step_t div_step(input logic [TOT_W-1:0] rem, input logic din,
                                     input logic [TOT_W-1:0] total);
    logic [TOT_W:0] trial;
    logic [TOT_W:0] diff;
    step_t          res;
    trial = {rem, din};
    diff  = trial - {1'b0, total};
    if (trial >= {1'b0, total}) begin
      res.rem = diff[TOT_W-1:0];
      res.q   = 1'b1;
    end else begin
      res.rem = trial[TOT_W-1:0];
      res.q   = 1'b0;
    end
    return res;
  endfunction

endpackage

@@ rtl/core/stereo_track_mixer.sv @@
// ----------------------------------------------------------------------------
// stereo_track_mixer: four-track stereo mixer with gain-normalized output
// Pipeline: the product, sum, divider stage and output registers lie between
// an accepted item and its done strobe; the sample width sets the divider stages.
// Throughput: one item per cycle; busy is low whenever reset is low.
// Reset: synchronous, clears the pipeline and loads the default gains and mode.
// The receiver cannot stall; each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module stereo_track_mixer (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [stm_pkg::SAMPLE_BITS-1:0]    sample_a,
  input  logic [stm_pkg::SAMPLE_BITS-1:0]    sample_b,
  input  logic [stm_pkg::SAMPLE_BITS-1:0]    sample_c,
  input  logic [stm_pkg::SAMPLE_BITS-1:0]    sample_d,
  input  logic                               cfg_write,
  input  logic [stm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [stm_pkg::CFG_W-1:0]          cfg_data,
  output logic                               done,
  output logic [stm_pkg::SAMPLE_BITS-1:0]    mix_left,
  output logic [stm_pkg::SAMPLE_BITS-1:0]    mix_right
);

  stm_pkg::cfg_t                                        cfg;
  logic                                                 accept;
  logic [stm_pkg::TRACKS-1:0][stm_pkg::SAMPLE_BITS-1:0] samples;
  logic [stm_pkg::TOT_W-1:0]                            total;
  logic [stm_pkg::TOT_W-1:0]                            total_next;
  logic                                                 total_zero;
  stm_pkg::prod_t                                       prod;
  stm_pkg::div_in_t                                     sum_l;
  stm_pkg::div_in_t                                     sum_r;
  stm_pkg::div_out_t                                    div_l;
  stm_pkg::div_out_t                                    div_r;

  // Items are taken in every cycle outside reset.
  assign busy   = rst;
  assign accept = start && !busy;
  assign samples = {sample_d, sample_c, sample_b, sample_a};

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < stm_pkg::TRACKS; k++) begin
        cfg.gains_left[k*stm_pkg::GAIN_BITS +: stm_pkg::GAIN_BITS] <=
          {1'b1, {(stm_pkg::GAIN_BITS-1){1'b0}}};
        cfg.gains_right[k*stm_pkg::GAIN_BITS +: stm_pkg::GAIN_BITS] <=
          {1'b1, {(stm_pkg::GAIN_BITS-1){1'b0}}};
      end
      cfg.track_enable <= 4'b1111;
      cfg.track_mode   <= stm_pkg::MODE_FOUR;
      cfg.track_map    <= 8'd228;
    end else if (cfg_write) begin
      case (cfg_index)
        stm_pkg::REG_GAINS_LEFT:   cfg.gains_left   <= cfg_data[stm_pkg::GREG_W-1:0];
        stm_pkg::REG_GAINS_RIGHT:  cfg.gains_right  <= cfg_data[stm_pkg::GREG_W-1:0];
        stm_pkg::REG_TRACK_ENABLE: cfg.track_enable <= cfg_data[stm_pkg::TRACKS-1:0];
        stm_pkg::REG_TRACK_MODE:   cfg.track_mode   <= cfg_data[1:0];
        stm_pkg::REG_TRACK_MAP:    cfg.track_map    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Total of all eight gains, registered since it only changes with configuration.
  always_comb begin
    total_next = '0;
    for (int k = 0; k < stm_pkg::TRACKS; k++) begin
      total_next = total_next
        + {3'b000, cfg.gains_left[k*stm_pkg::GAIN_BITS +: stm_pkg::GAIN_BITS]}
        + {3'b000, cfg.gains_right[k*stm_pkg::GAIN_BITS +: stm_pkg::GAIN_BITS]};
    end
  end

  always_ff @(posedge clk) begin
    total      <= total_next;
    total_zero <= (total_next == '0);
  end

  // Datapath: products, sums, one divider per channel.
  stm_mult u_mult (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .samples  (samples),
    .cfg      (cfg),
    .prod     (prod)
  );

  stm_sum u_sum (
    .clk   (clk),
    .rst   (rst),
    .prod  (prod),
    .sum_l (sum_l),
    .sum_r (sum_r)
  );

  stm_div u_div_l (
    .clk   (clk),
    .rst   (rst),
    .din   (sum_l),
    .total (total),
    .dout  (div_l)
  );

  stm_div u_div_r (
    .clk   (clk),
    .rst   (rst),
    .din   (sum_r),
    .total (total),
    .dout  (div_r)
  );

  // Output register: restore the sign; a zero gain total gives silence.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= div_l.valid;
    end
    if (total_zero) begin
      mix_left  <= '0;
      mix_right <= '0;
    end else begin
      mix_left  <= div_l.neg ? -div_l.quo : div_l.quo;
      mix_right <= div_r.neg ? -div_r.quo : div_r.quo;
    end
  end

  // Every accepted item leaves after the fixed latency.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##(stm_pkg::LATENCY) done)
    else $error("accepted item did not produce a result on time");

  // Both channel dividers stay in step.
  a_lanes: assert property (@(posedge clk) disable iff (rst)
    div_l.valid == div_r.valid)
    else $error("left and right divider pipelines out of step");

  // A zero gain total yields silence on both channels.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    done && total_zero |-> mix_left == '0 && mix_right == '0)
    else $error("nonzero output with zero gain total");

  // No result right after reset.
  a_reset: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe right after reset");

endmodule

@@ rtl/core/stm_mult.sv @@
// ----------------------------------------------------------------------------
// stm_mult: track selection and gain products
// Routes the input samples to the four track slots by mode and map, silences
// inactive or disabled slots, and registers the eight sample-gain products.
// ----------------------------------------------------------------------------
module stm_mult (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           in_valid,
  input  logic [stm_pkg::TRACKS-1:0][stm_pkg::SAMPLE_BITS-1:0] samples,
  input  stm_pkg::cfg_t                                  cfg,
  output stm_pkg::prod_t                                 prod
);

  logic [stm_pkg::TRACKS-1:0]                               active;
  logic [stm_pkg::TRACKS-1:0][stm_pkg::SAMPLE_BITS-1:0]     slot_sample;
  logic [stm_pkg::TRACKS-1:0][stm_pkg::PROD_W-1:0]          prod_l_next;
  logic [stm_pkg::TRACKS-1:0][stm_pkg::PROD_W-1:0]          prod_r_next;
  logic signed [stm_pkg::SAMPLE_BITS-1:0]                   smp;
  logic signed [stm_pkg::GAIN_BITS:0]                       gl;
  logic signed [stm_pkg::GAIN_BITS:0]                       gr;
  logic signed [stm_pkg::PROD_W-1:0]                        pl;
  logic signed [stm_pkg::PROD_W-1:0]                        pr;

  // Slots that take part in the current mode.
  always_comb begin
    case (cfg.track_mode)
      stm_pkg::MODE_ONE: active = 4'b0001;
      stm_pkg::MODE_TWO: active = 4'b0011;
      default:           active = 4'b1111;
    endcase
  end

  // Source of each slot: the map in four-track mode, the slot's own input otherwise.
  always_comb begin
    for (int k = 0; k < stm_pkg::TRACKS; k++) begin
      if (cfg.track_mode == stm_pkg::MODE_ONE || cfg.track_mode == stm_pkg::MODE_TWO) begin
        slot_sample[k] = samples[k];
      end else begin
        slot_sample[k] = samples[cfg.track_map[2*k +: 2]];
      end
    end
  end

  // One product per slot and channel; a silent slot gives zero.
  always_comb begin
    smp = '0;
    gl  = '0;
    gr  = '0;
    pl  = '0;
    pr  = '0;
    for (int k = 0; k < stm_pkg::TRACKS; k++) begin
      smp = $signed(slot_sample[k]);
      gl  = $signed({1'b0, cfg.gains_left[k*stm_pkg::GAIN_BITS +: stm_pkg::GAIN_BITS]});
      gr  = $signed({1'b0, cfg.gains_right[k*stm_pkg::GAIN_BITS +: stm_pkg::GAIN_BITS]});
      pl  = stm_pkg::PROD_W'(smp) * stm_pkg::PROD_W'(gl);
      pr  = stm_pkg::PROD_W'(smp) * stm_pkg::PROD_W'(gr);
      if (active[k] && cfg.track_enable[k]) begin
        prod_l_next[k] = pl;
        prod_r_next[k] = pr;
      end else begin
        prod_l_next[k] = '0;
        prod_r_next[k] = '0;
      end
    end
  end

  // Product register.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod.valid <= 1'b0;
    end else begin
      prod.valid <= in_valid;
    end
    prod.left  <= prod_l_next;
    prod.right <= prod_r_next;
  end

endmodule

@@ rtl/core/stm_sum.sv @@
// ----------------------------------------------------------------------------
// stm_sum: weighted sums of one item
// Adds the four products of each channel and splits the sum into a sign and
// a magnitude for the unsigned divider.
// ----------------------------------------------------------------------------
module stm_sum (
  input  logic              clk,
  input  logic              rst,
  input  stm_pkg::prod_t    prod,
  output stm_pkg::div_in_t  sum_l,
  output stm_pkg::div_in_t  sum_r
);

  logic signed [stm_pkg::ACC_W-1:0] acc_l;
  logic signed [stm_pkg::ACC_W-1:0] acc_r;

  // Signed sums of the four slots.
  always_comb begin
    acc_l = '0;
    acc_r = '0;
    for (int k = 0; k < stm_pkg::TRACKS; k++) begin
      acc_l = acc_l + stm_pkg::ACC_W'($signed(prod.left[k]));
      acc_r = acc_r + stm_pkg::ACC_W'($signed(prod.right[k]));
    end
  end

  // Sign and magnitude register.
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_l.valid <= 1'b0;
      sum_r.valid <= 1'b0;
    end else begin
      sum_l.valid <= prod.valid;
      sum_r.valid <= prod.valid;
    end
    sum_l.neg <= acc_l[stm_pkg::ACC_W-1];
    sum_r.neg <= acc_r[stm_pkg::ACC_W-1];
    sum_l.mag <= acc_l[stm_pkg::ACC_W-1] ? -acc_l : acc_l;
    sum_r.mag <= acc_r[stm_pkg::ACC_W-1] ? -acc_r : acc_r;
  end

endmodule

@@ rtl/core/stm_div.sv @@
// ----------------------------------------------------------------------------
// stm_div: pipelined restoring divider for one channel
// Divides the magnitude of a channel sum by the gain total, a few quotient
// bits per register stage, and carries the sign alongside.
// ----------------------------------------------------------------------------
module stm_div (
  input  logic                         clk,
  input  logic                         rst,
  input  stm_pkg::div_in_t             din,
  input  logic [stm_pkg::TOT_W-1:0]    total,
  output stm_pkg::div_out_t            dout
);

  // Stage registers: remainder, and dividend bits that turn into quotient bits.
  logic [stm_pkg::TOT_W-1:0]       rem   [stm_pkg::DIV_STAGES];
  logic [stm_pkg::SAMPLE_BITS-1:0] work  [stm_pkg::DIV_STAGES];
  logic                            neg   [stm_pkg::DIV_STAGES];
  logic                            valid [stm_pkg::DIV_STAGES];

  genvar st;
  for (st = 0; st < stm_pkg::DIV_STAGES; st++) begin : g_stage
    logic [stm_pkg::TOT_W-1:0]       rem_src;
    logic [stm_pkg::SAMPLE_BITS-1:0] work_src;
    logic                            neg_src;
    logic                            valid_src;
    logic [stm_pkg::TOT_W-1:0]       rem_next;
    logic [stm_pkg::SAMPLE_BITS-1:0] work_next;
    stm_pkg::step_t                  s;

    // The quotient fits the sample width, so the high bits seed the remainder.
    if (st == 0) begin : g_first
      assign rem_src   = din.mag[stm_pkg::MAG_W-1:stm_pkg::SAMPLE_BITS];
      assign work_src  = din.mag[stm_pkg::SAMPLE_BITS-1:0];
      assign neg_src   = din.neg;
      assign valid_src = din.valid;
    end else begin : g_next
      assign rem_src   = rem[st-1];
      assign work_src  = work[st-1];
      assign neg_src   = neg[st-1];
      assign valid_src = valid[st-1];
    end

    // Division steps of this stage; the last stage may hold fewer.
    always_comb begin
      rem_next  = rem_src;
      work_next = work_src;
      s         = '0;
      for (int j = 0; j < stm_pkg::DIV_STEPS; j++) begin
        if (st * stm_pkg::DIV_STEPS + j < stm_pkg::SAMPLE_BITS) begin
          s         = stm_pkg::div_step(rem_next, work_next[stm_pkg::SAMPLE_BITS-1], total);
          rem_next  = s.rem;
          work_next = {work_next[stm_pkg::SAMPLE_BITS-2:0], s.q};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[st] <= 1'b0;
      end else begin
        valid[st] <= valid_src;
      end
      rem[st]  <= rem_next;
      work[st] <= work_next;
      neg[st]  <= neg_src;
    end
  end

  // After the last stage the dividend bits have become the quotient.
  assign dout.valid = valid[stm_pkg::DIV_STAGES-1];
  assign dout.neg   = neg[stm_pkg::DIV_STAGES-1];
  assign dout.quo   = work[stm_pkg::DIV_STAGES-1];

endmodule

@@ dv/stereo_track_mixer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_track_mixer_tb: self-checking bench for the four-track stereo mixer
// Frames of four samples go in through the start/busy handshake. A local
// predictor turns each accepted frame into the expected left and right mix
// under the current gains, enables, mode and slot map. Each done strobe is
// checked against the oldest expected mix. Directed frames cover the sample
// extremes, every mode, disabled slots, zero and full gains and writes to
// unused register indexes. Random phases then reload the registers and push
// bursts of frames with random gaps.
// ----------------------------------------------------------------------------
module stereo_track_mixer_tb;
  import stm_pkg::*;

  // Mode code with no meaning of its own; it acts as four-track mode.
  localparam logic [1:0] MODE_SPARE = 2'd3;

  typedef logic [TRACKS-1:0][SAMPLE_BITS-1:0] frame_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] left;
    logic [SAMPLE_BITS-1:0] right;
  } mix_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  logic [SAMPLE_BITS-1:0] sample_a = '0;
  logic [SAMPLE_BITS-1:0] sample_b = '0;
  logic [SAMPLE_BITS-1:0] sample_c = '0;
  logic [SAMPLE_BITS-1:0] sample_d = '0;
  logic                   cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;
  logic                   done;
  logic [SAMPLE_BITS-1:0] mix_left;
  logic [SAMPLE_BITS-1:0] mix_right;

  // Register values as the mixer should hold them.
  logic [GREG_W-1:0] cur_gains_left;
  logic [GREG_W-1:0] cur_gains_right;
  logic [TRACKS-1:0] cur_enable;
  logic [1:0]        cur_mode;
  logic [7:0]        cur_map;

  mix_t expected_mix[$];
  int   mismatches = 0;
  int   burst_left = 1;

  stereo_track_mixer u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .sample_a  (sample_a),
    .sample_b  (sample_b),
    .sample_c  (sample_c),
    .sample_d  (sample_d),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .done      (done),
    .mix_left  (mix_left),
    .mix_right (mix_right)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Weighted sum over the active, enabled slots, divided by the total of
  // all eight gains with truncation toward zero.
  function automatic mix_t mix_frame(input frame_t f);
    longint acc_l;
    longint acc_r;
    longint total;
    longint s;
    int     n_slots;
    int     src;
    mix_t   m;
    acc_l = 0;
    acc_r = 0;
    total = 0;
    for (int k = 0; k < TRACKS; k++) begin
      total += longint'(cur_gains_left[k*GAIN_BITS +: GAIN_BITS]);
      total += longint'(cur_gains_right[k*GAIN_BITS +: GAIN_BITS]);
    end
    if (cur_mode == MODE_ONE) n_slots = 1;
    else if (cur_mode == MODE_TWO) n_slots = 2;
    else n_slots = TRACKS;
    for (int k = 0; k < n_slots; k++) begin
      src = (n_slots == TRACKS) ? int'(cur_map[2*k +: 2]) : k;
      if (cur_enable[k]) begin
        s = longint'($signed(f[src]));
        acc_l += s * longint'(cur_gains_left[k*GAIN_BITS +: GAIN_BITS]);
        acc_r += s * longint'(cur_gains_right[k*GAIN_BITS +: GAIN_BITS]);
      end
    end
    if (total == 0) begin
      m = '0;
    end else begin
      m.left  = SAMPLE_BITS'(acc_l / total);
      m.right = SAMPLE_BITS'(acc_r / total);
    end
    return m;
  endfunction

  // Sample values weighted toward full scale and zero.
  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      1: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      2: return '0;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Packed gains: sometimes all zero or all full, else bytes of mixed kinds.
  function automatic logic [GREG_W-1:0] pick_gains();
    logic [GREG_W-1:0] g;
    case ($urandom_range(0, 7))
      0: g = '0;
      1: g = '1;
      default: begin
        for (int k = 0; k < TRACKS; k++) begin
          case ($urandom_range(0, 3))
            0: g[k*GAIN_BITS +: GAIN_BITS] = '0;
            1: g[k*GAIN_BITS +: GAIN_BITS] = '1;
            default: g[k*GAIN_BITS +: GAIN_BITS] = GAIN_BITS'($urandom);
          endcase
        end
      end
    endcase
    return g;
  endfunction

  // One register write; the caller lowers the write enable after the last.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_GAINS_LEFT:   cur_gains_left  = data[GREG_W-1:0];
      REG_GAINS_RIGHT:  cur_gains_right = data[GREG_W-1:0];
      REG_TRACK_ENABLE: cur_enable      = data[TRACKS-1:0];
      REG_TRACK_MODE:   cur_mode        = data[1:0];
      REG_TRACK_MAP:    cur_map         = data[7:0];
      default: ;
    endcase
  endtask

  // Stop sending and wait until every expected mix has come out.
  task automatic drain();
    start <= 1'b0;
    while (expected_mix.size() != 0) @(posedge clk);
  endtask

  // Load all five registers; drains the pipeline first.
  task automatic load_config(input logic [GREG_W-1:0] gl, input logic [GREG_W-1:0] gr,
                             input logic [TRACKS-1:0] en, input logic [1:0] mode,
                             input logic [7:0] map);
    drain();
    write_reg(REG_GAINS_LEFT, CFG_W'(gl));
    write_reg(REG_GAINS_RIGHT, CFG_W'(gr));
    // Junk in the upper data bits must be masked off by the block.
    write_reg(REG_TRACK_ENABLE, {$urandom} << TRACKS | CFG_W'(en));
    write_reg(REG_TRACK_MODE, {$urandom} << 2 | CFG_W'(mode));
    write_reg(REG_TRACK_MAP, {$urandom} << 8 | CFG_W'(map));
    cfg_write <= 1'b0;
  endtask

  // Send one item, predict its mix once accepted, then maybe open a gap.
  task automatic send_frame(input logic [SAMPLE_BITS-1:0] a, input logic [SAMPLE_BITS-1:0] b,
                            input logic [SAMPLE_BITS-1:0] c, input logic [SAMPLE_BITS-1:0] d);
    int gap;
    start    <= 1'b1;
    sample_a <= a;
    sample_b <= b;
    sample_c <= c;
    sample_d <= d;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_mix.push_back(mix_frame({d, c, b, a}));
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Default registers: half gain everywhere, four-track identity map.
  task automatic test_default_frames();
    send_frame(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_frame(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_frame(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_frame(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
    send_frame(16'h5555, 16'hAAAA, 16'h0001, 16'hFFFF);
  endtask

  // Every mode, including the spare code, with a reversed slot map.
  task automatic test_track_modes();
    logic [1:0] modes[4];
    modes = '{MODE_ONE, MODE_TWO, MODE_FOUR, MODE_SPARE};
    foreach (modes[i]) begin
      load_config(32'h40FF_0180, 32'h0180_40FF, 4'hF, modes[i], 8'h1B);
      send_frame(16'h7FFF, 16'hFFFF, 16'h1234, 16'h8000);
      send_frame(16'h8001, 16'h0100, 16'hC000, 16'h3FFF);
    end
  endtask

  // Disabled slots give silence but keep their gains in the total.
  task automatic test_slot_enable();
    load_config('1, '1, 4'b0101, MODE_FOUR, 8'hE4);
    send_frame(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
    load_config('1, '1, 4'b0000, MODE_FOUR, 8'hE4);
    send_frame(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
    load_config('1, '1, 4'b1000, MODE_FOUR, 8'hE4);
    send_frame(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
  endtask

  // Zero total, full gains, one lone gain and a gain on an inactive slot only.
  task automatic test_gain_extremes();
    load_config('0, '0, 4'hF, MODE_FOUR, 8'hE4);
    send_frame(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
    load_config('1, '1, 4'hF, MODE_FOUR, 8'hE4);
    send_frame(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    load_config(32'h0000_00FF, '0, 4'hF, MODE_FOUR, 8'hE4);
    send_frame(16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    load_config(32'hFF00_0000, 32'h00FF_0000, 4'hF, MODE_ONE, 8'hE4);
    send_frame(16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF);
  endtask

  // Writes to indexes past the register list must change nothing.
  task automatic test_unused_index();
    load_config(32'h1020_4080, 32'h8040_2010, 4'b1011, MODE_FOUR, 8'h9C);
    // One idle cycle so the write enable is not driven twice in one step.
    @(posedge clk);
    for (int i = int'(REG_TRACK_MAP) + 1; i < (1 << CFG_IDX_W); i++)
      write_reg(CFG_IDX_W'(i), '1);
    cfg_write <= 1'b0;
    send_frame(16'h7FFF, 16'h8000, 16'h4000, 16'hC001);
  endtask

  // Random register settings, each followed by a burst of random frames.
  task automatic test_random_mix(input int phases, input int per_phase);
    logic [1:0] mode;
    for (int p = 0; p < phases; p++) begin
      mode = 2'($urandom_range(0, 3));
      load_config(pick_gains(), pick_gains(), 4'($urandom), mode, 8'($urandom));
      for (int i = 0; i < per_phase; i++)
        send_frame(pick_sample(), pick_sample(), pick_sample(), pick_sample());
    end
  endtask

  // Compare each result with the oldest expected mix.
  always @(posedge clk) begin
    mix_t want;
    if (!rst && done) begin
      if (expected_mix.size() == 0) begin
        $display("%0t: unexpected result left %h right %h", $time, mix_left, mix_right);
        mismatches++;
      end else begin
        want = expected_mix.pop_front();
        if (mix_left !== want.left) begin
          $display("%0t: mix_left expected %h actual %h", $time, want.left, mix_left);
          mismatches++;
        end
        if (mix_right !== want.right) begin
          $display("%0t: mix_right expected %h actual %h", $time, want.right, mix_right);
          mismatches++;
        end
      end
    end
  end

  initial begin
    cur_gains_left  = {TRACKS{8'h80}};
    cur_gains_right = {TRACKS{8'h80}};
    cur_enable      = 4'hF;
    cur_mode        = MODE_FOUR;
    cur_map         = 8'hE4;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);

    test_default_frames();
    test_track_modes();
    test_slot_enable();
    test_gain_extremes();
    test_unused_index();
    test_random_mix(30, 35);

    drain();
    repeat (LATENCY + 4) @(posedge clk);
    if (mismatches == 0 && expected_mix.size() == 0) begin
      $display("SUCCESS");
    end else begin
      if (expected_mix.size() != 0)
        $display("%0t: %0d expected results never arrived", $time, expected_mix.size());
      $display("FAILURE");
    end
    $finish;
  end

  // Safety net against a hung handshake.
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
